@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check on clk_i, off while in reset
`define CHK_ON_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// concurrent implication check on clk_i
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

@@ rtl/bspk_pkg.sv @@
// types, constants and scale table of the boxcar peak search
`default_nettype none
package bspk_pkg;
  localparam int unsigned NUM_WIDTHS = 16;
  localparam int unsigned HIST_LEN   = NUM_WIDTHS - 1;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = 21;
  localparam int unsigned PEAK_W     = 19;
  localparam int unsigned WID_W      = 5;
  localparam int unsigned ROW_W      = HIST_LEN * SAMPLE_W;
  localparam int unsigned ADDR_W     = 14;
  localparam int unsigned CFG_W      = 19;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DM_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIX_COUNT = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [3:0]                 dm_index;
    logic [15:0]                time_index;
    logic [9:0]                 pixel_index;
    logic                       start_of_block;
  } in_req_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak_snr;
    logic [9:0]        cand_pixel;
    logic [WID_W-1:0]  peak_width;
    logic [15:0]       cand_time;
    logic [3:0]        cand_dm;
  } out_req_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
    logic [PEAK_W-1:0]       best;
    logic [WID_W-1:0]        width;
  } link_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_RUN, ST_OUT
  } state_e;

  // q1.15 value of 1/sqrt(w) for width w = k + 1
  function automatic logic [15:0] inv_sqrt(input logic [3:0] k);
    logic [15:0] r;
    case (k)
      4'd0:    r = 16'd32768;
      4'd1:    r = 16'd23170;
      4'd2:    r = 16'd18919;
      4'd3:    r = 16'd16384;
      4'd4:    r = 16'd14654;
      4'd5:    r = 16'd13377;
      4'd6:    r = 16'd12385;
      4'd7:    r = 16'd11585;
      4'd8:    r = 16'd10923;
      4'd9:    r = 16'd10362;
      4'd10:   r = 16'd9880;
      4'd11:   r = 16'd9459;
      4'd12:   r = 16'd9088;
      4'd13:   r = 16'd8758;
      4'd14:   r = 16'd8461;
      4'd15:   r = 16'd8192;
      default: r = 16'd8192;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/boxcar_snr_peak_search.sv @@
// top level: history memory, cell chain, candidate limit and control
//
//  channel | dir | handshake               | payload
//  in      | in  | in_valid_i / in_stall_o | in_req_i (in_req_t)
//  out     | out | out_valid_o/out_stall_i | out_req_o (out_req_t)
//  cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// an in-range request goes through one memory read, then the chain of width
// cells, then the decision; the next request is accepted only once the block
// is idle again, after any candidate output and its output stall.
// out-of-range requests are dropped in the accepting cycle.
// after reset a clearing pass zeroes the 16384 history rows with in_stall_o
// high; config writes are taken throughout.
// a stalled result holds the block until it is taken.
`default_nettype none
`include "assert_macros.svh"
module boxcar_snr_peak_search import bspk_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_req_t              in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_req_t                  out_req_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);
  state_e            state_d, state_q;
  logic [ADDR_W-1:0] clr_d, clr_q;
  logic [PEAK_W-1:0] thr_q;
  logic [15:0]       max_q;
  logic [4:0]        dmc_q;
  logic [10:0]       pixc_q;
  logic [15:0]       cnt_d, cnt_q;
  in_req_t           item_q;
  out_req_t          out_d, out_q;
  logic [ROW_W-1:0]  row_q;
  logic [ROW_W-1:0]  mem [2**ADDR_W];
  logic              accept, in_range, emit;
  logic [ADDR_W-1:0] in_addr, item_addr;
  link_t             link [NUM_WIDTHS+1];

  assign accept    = in_valid_i && !in_stall_o;
  assign in_range  = (5'(in_req_i.dm_index) < dmc_q) && (11'(in_req_i.pixel_index) < pixc_q);
  assign in_addr   = {in_req_i.dm_index, in_req_i.pixel_index};
  assign item_addr = {item_q.dm_index, item_q.pixel_index};
  assign emit = (link[NUM_WIDTHS].best != '0) && (link[NUM_WIDTHS].best >= thr_q)
                && (cnt_q < max_q);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 19'd1024;
      max_q  <= 16'd4096;
      dmc_q  <= 5'd16;
      pixc_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thr_q  <= cfg_data_i;
        REG_MAX_CAND:  max_q  <= cfg_data_i[15:0];
        REG_DM_COUNT:  dmc_q  <= cfg_data_i[4:0];
        REG_PIX_COUNT: pixc_q <= cfg_data_i[10:0];
        default:       thr_q  <= thr_q;
      endcase
    end
  end

  // history memory: clear sweep, read on accept, shifted write-back
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mem[clr_q] <= '0;
    end else if (state_q == ST_READ) begin
      mem[item_addr] <= {row_q[ROW_W-SAMPLE_W-1:0], item_q.sample};
    end
    if (accept && in_range) begin
      row_q  <= mem[in_addr];
      item_q <= in_req_i;
    end
  end

  // chain of width cells
  assign link[0] = '{valid: (state_q == ST_READ), sum: '0, best: '0, width: '0};
  for (genvar k = 0; k < NUM_WIDTHS; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] add;
    if (k == 0) begin : g_first
      assign add = item_q.sample;
    end else begin : g_rest
      assign add = row_q[(k-1)*SAMPLE_W +: SAMPLE_W];
    end
    bspk_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .link_i (link[k]),
      .add_i  (add),
      .scale_i(inv_sqrt(4'(k))),
      .wid_i  (WID_W'(k + 1)),
      .link_o (link[k+1])
    );
  end

  // next state, count and result
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == {ADDR_W{1'b1}}) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_range) begin
          state_d = ST_READ;
          if (in_req_i.start_of_block) cnt_d = '0;
        end
      end
      ST_READ: state_d = ST_RUN;
      ST_RUN: begin
        if (link[NUM_WIDTHS].valid) begin
          if (emit) begin
            state_d = ST_OUT;
            cnt_d   = cnt_q + 1'b1;
            out_d.peak_snr   = link[NUM_WIDTHS].best;
            out_d.cand_pixel = item_q.pixel_index;
            out_d.peak_width = link[NUM_WIDTHS].width;
            out_d.cand_time  = item_q.time_index;
            out_d.cand_dm    = item_q.dm_index;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_req_o = out_q;

  // checks
  `CHK_IMPL(a_out_nonzero, out_valid_o, (out_req_o.peak_snr != '0) && (out_req_o.peak_width != '0), "result with empty peak")
  `CHK_IMPL(a_cnt_limit, $rose(out_valid_o), cnt_q <= max_q, "candidate limit exceeded")
  `CHK_IMPL(a_chain_busy, link[NUM_WIDTHS].valid, state_q == ST_RUN, "chain result outside run")
  `CHK_ON_CLK(a_one_in_chain, $countones({link[1].valid, link[8].valid, link[16].valid}) <= 1, "two requests in chain")
endmodule
`default_nettype wire

@@ rtl/bspk_cell.sv @@
// one boxcar width: extend the sum, scale it, keep the running peak
`default_nettype none
module bspk_cell import bspk_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire link_t                      link_i,
  input  wire logic signed [SAMPLE_W-1:0] add_i,
  input  wire logic [15:0]                scale_i,
  input  wire logic [WID_W-1:0]           wid_i,
  output link_t                           link_o
);
  logic signed [SUM_W-1:0] sum;
  logic [35:0]             prod;
  logic [20:0]             scaled;
  logic [PEAK_W-1:0]       sat;
  logic                    better;
  link_t                   link_d, link_q;

  // sum for this width; its scaled value counts only when the sum is positive
  always_comb begin
    sum    = link_i.sum + SUM_W'(add_i);
    prod   = 36'(sum[19:0]) * 36'(scale_i);
    scaled = prod[35:15];
    sat    = (scaled > 21'(2**PEAK_W - 1)) ? {PEAK_W{1'b1}} : scaled[PEAK_W-1:0];
    better = (sum > 0) && (sat > link_i.best);
    link_d.valid = link_i.valid;
    link_d.sum   = sum;
    link_d.best  = better ? sat : link_i.best;
    link_d.width = better ? wid_i : link_i.width;
  end

  // hand over to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;
endmodule
`default_nettype wire
